// ===== hw/rtl/amou_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// amou_pkg
// Shared types and codes for the atomic memory operation unit: operation and
// status codes, controller states and the command bundle to the datapath.
// ----------------------------------------------------------------------------
package amou_pkg;

    typedef enum logic [3:0] {
        OP_LR   = 4'd0,
        OP_SC   = 4'd1,
        OP_SWAP = 4'd2,
        OP_ADD  = 4'd3,
        OP_XOR  = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_MIN  = 4'd7,
        OP_MAX  = 4'd8,
        OP_MINU = 4'd9,
        OP_MAXU = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_ILLEGAL = 2'd1,
        STATUS_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage : amou_pkg
`default_nettype wire

// ===== hw/rtl/atomic_memory_op_unit_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atomic_memory_op_unit_core
// RV32A atomic memory operation unit with a bounded LR reservation table.
// ----------------------------------------------------------------------------
// Usage: a request arrives on the in_* channel (valid/ready) carrying the op,
// the address, the rs2 operand, the rs2 register number and the current memory
// word at that address. Exactly one result leaves on the out_* channel with
// the rd write, the memory write and a status code.
// Flow: the controller walks idle, execute and done in turn and takes no new
// request until the receiver has taken the last result. The request is
// registered on acceptance; the reservation lookup, table update and AMO
// arithmetic happen in the execute state, which loads the result registers.
// Stall: while out_ready is low the result is held stable in the output
// registers and in_ready stays low, so no request is lost or overtaken.
// Reset: rst_n clears all reservation valid bits, the round-robin victim
// pointer and the controller, so the block comes up idle and ready with no
// reservations held. Reserved addresses are not cleared; a clear valid bit
// hides them.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit_core
#(
    parameter int RESERVATION_ENTRIES = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [3:0]  op,
    input  wire logic [31:0] address,
    input  wire logic [31:0] operand_value,
    input  wire logic [4:0]  rs2_index,
    input  wire logic [31:0] memory_word,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        rd_write,
    output      logic [31:0] rd_value,
    output      logic        mem_write,
    output      logic [31:0] mem_write_value,
    output      logic [1:0]  status
);

    // Command bundle from the controller into the datapath.
    amou_pkg::cmd_t cmd;

    // The controller owns the handshake and tells the datapath when to
    // capture a request and when to execute it.
    amou_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the reservation table and produces the result
    // registers that drive the output payload directly.
    amou_dp
    #(
        .RESERVATION_ENTRIES (RESERVATION_ENTRIES)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .op              (op),
        .address         (address),
        .operand_value   (operand_value),
        .rs2_index       (rs2_index),
        .memory_word     (memory_word),
        .rd_write        (rd_write),
        .rd_value        (rd_value),
        .mem_write       (mem_write),
        .mem_write_value (mem_write_value),
        .status          (status)
    );

endmodule : atomic_memory_op_unit_core
`default_nettype wire

// ===== hw/rtl/amou_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// amou_ctrl
// Controller state machine: accepts a request, sequences the execute step and
// holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module amou_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_ready,
    output      logic          out_valid,
    input  wire logic          out_ready,
    output      amou_pkg::cmd_t cmd
);

    amou_pkg::state_t state_reg;
    amou_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= amou_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amou_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = amou_pkg::ST_EXEC;
                end
            end
            amou_pkg::ST_EXEC:
            begin
                state_next = amou_pkg::ST_DONE;
            end
            amou_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = amou_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = amou_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            amou_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            amou_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
            end
            amou_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule : amou_ctrl
`default_nettype wire

// ===== hw/rtl/amou_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// amou_dp
// Datapath: request registers, reservation table with round-robin victim
// pointer, AMO arithmetic and the result registers.
// ----------------------------------------------------------------------------
module amou_dp
#(
    parameter int RESERVATION_ENTRIES = 4
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire amou_pkg::cmd_t cmd,
    input  wire logic [3:0]     op,
    input  wire logic [31:0]    address,
    input  wire logic [31:0]    operand_value,
    input  wire logic [4:0]     rs2_index,
    input  wire logic [31:0]    memory_word,
    output      logic           rd_write,
    output      logic [31:0]    rd_value,
    output      logic           mem_write,
    output      logic [31:0]    mem_write_value,
    output      logic [1:0]     status
);

    localparam int IDX_W = (RESERVATION_ENTRIES > 1) ? $clog2(RESERVATION_ENTRIES) : 1;

    // Captured request.
    logic [3:0]  op_reg;
    logic [31:0] addr_reg;
    logic [31:0] src_reg;
    logic [4:0]  rs2_reg;
    logic [31:0] mem_reg;

    // Reservation table.
    logic [31:0]                    res_addr_reg [RESERVATION_ENTRIES];
    logic [RESERVATION_ENTRIES-1:0] res_valid_reg;
    logic [IDX_W-1:0]               victim_reg;

    // Result registers.
    logic        rd_write_reg;
    logic [31:0] rd_value_reg;
    logic        mem_write_reg;
    logic [31:0] mem_write_value_reg;
    logic [1:0]  status_reg;

    logic             any_hit;
    logic [IDX_W-1:0] hit_idx;
    logic             any_free;
    logic [IDX_W-1:0] free_idx;
    logic [31:0]      amo_value;
    logic             lr_reserve;
    logic             sc_clear;

    logic        rd_write_next;
    logic [31:0] rd_value_next;
    logic        mem_write_next;
    logic [31:0] mem_write_value_next;
    logic [1:0]  status_next;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            addr_reg <= address;
            src_reg  <= operand_value;
            rs2_reg  <= rs2_index;
            mem_reg  <= memory_word;
        end
    end

    // Parallel lookup; the lowest matching or free entry wins.
    always_comb
    begin
        any_hit  = 1'b0;
        hit_idx  = '0;
        any_free = 1'b0;
        free_idx = '0;
        for (int i = RESERVATION_ENTRIES - 1; i >= 0; i--)
        begin
            if (res_valid_reg[i] && (res_addr_reg[i] == addr_reg))
            begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!res_valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        amo_value = src_reg;
        unique case (amou_pkg::op_t'(op_reg))
            amou_pkg::OP_ADD:  amo_value = mem_reg + src_reg;
            amou_pkg::OP_XOR:  amo_value = mem_reg ^ src_reg;
            amou_pkg::OP_AND:  amo_value = mem_reg & src_reg;
            amou_pkg::OP_OR:   amo_value = mem_reg | src_reg;
            amou_pkg::OP_MIN:
                amo_value = ($signed(mem_reg) < $signed(src_reg)) ? mem_reg : src_reg;
            amou_pkg::OP_MAX:
                amo_value = ($signed(mem_reg) > $signed(src_reg)) ? mem_reg : src_reg;
            amou_pkg::OP_MINU: amo_value = (mem_reg < src_reg) ? mem_reg : src_reg;
            amou_pkg::OP_MAXU: amo_value = (mem_reg > src_reg) ? mem_reg : src_reg;
            default:           amo_value = src_reg;
        endcase
    end

    always_comb
    begin
        rd_write_next        = 1'b0;
        rd_value_next        = '0;
        mem_write_next       = 1'b0;
        mem_write_value_next = '0;
        status_next          = amou_pkg::STATUS_DONE;
        lr_reserve           = 1'b0;
        sc_clear             = 1'b0;
        unique case (amou_pkg::op_t'(op_reg))
            amou_pkg::OP_LR:
            begin
                if (rs2_reg != 5'd0)
                begin
                    status_next = amou_pkg::STATUS_ILLEGAL;
                end
                else
                begin
                    rd_write_next = 1'b1;
                    rd_value_next = mem_reg;
                    lr_reserve    = !any_hit;
                end
            end
            amou_pkg::OP_SC:
            begin
                rd_write_next = 1'b1;
                if (any_hit)
                begin
                    sc_clear             = 1'b1;
                    mem_write_next       = 1'b1;
                    mem_write_value_next = src_reg;
                end
                else
                begin
                    rd_value_next = 32'd1;
                end
            end
            amou_pkg::OP_SWAP, amou_pkg::OP_ADD, amou_pkg::OP_XOR, amou_pkg::OP_AND,
            amou_pkg::OP_OR, amou_pkg::OP_MIN, amou_pkg::OP_MAX, amou_pkg::OP_MINU,
            amou_pkg::OP_MAXU:
            begin
                rd_write_next        = 1'b1;
                rd_value_next        = mem_reg;
                mem_write_next       = 1'b1;
                mem_write_value_next = amo_value;
            end
            default:
            begin
                status_next = amou_pkg::STATUS_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= '0;
            victim_reg    <= '0;
        end
        else if (cmd.execute)
        begin
            if (lr_reserve)
            begin
                if (any_free)
                begin
                    res_valid_reg[free_idx] <= 1'b1;
                end
                else
                begin
                    res_valid_reg[victim_reg] <= 1'b1;
                    if (victim_reg == IDX_W'(RESERVATION_ENTRIES - 1))
                    begin
                        victim_reg <= '0;
                    end
                    else
                    begin
                        victim_reg <= victim_reg + IDX_W'(1);
                    end
                end
            end
            else if (sc_clear)
            begin
                res_valid_reg[hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && lr_reserve)
        begin
            if (any_free)
            begin
                res_addr_reg[free_idx] <= addr_reg;
            end
            else
            begin
                res_addr_reg[victim_reg] <= addr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rd_write_reg        <= rd_write_next;
            rd_value_reg        <= rd_value_next;
            mem_write_reg       <= mem_write_next;
            mem_write_value_reg <= mem_write_value_next;
            status_reg          <= status_next;
        end
    end

    assign rd_write        = rd_write_reg;
    assign rd_value        = rd_value_reg;
    assign mem_write       = mem_write_reg;
    assign mem_write_value = mem_write_value_reg;
    assign status          = status_reg;

endmodule : amou_dp
`default_nettype wire

// ===== dv/atomic_memory_op_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atomic_memory_op_unit_checker
// Watches the request and result channels of the atomic unit, predicts the result of
// every accepted request from its own copy of the reservation table, and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit_checker
#(
    parameter int ENTRIES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [3:0]  op,
    input  logic [31:0] address,
    input  logic [31:0] operand_value,
    input  logic [4:0]  rs2_index,
    input  logic [31:0] memory_word,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        rd_write,
    input  logic [31:0] rd_value,
    input  logic        mem_write,
    input  logic [31:0] mem_write_value,
    input  logic [1:0]  status,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic              rd_write;
        logic [31:0]       rd_value;
        logic              mem_write;
        logic [31:0]       mem_write_value;
        amou_pkg::status_t status;
    } atomic_result_t;

    // Shadow reservation table.
    logic [31:0]    resv_addr [ENTRIES];
    bit             resv_valid [ENTRIES];
    int             victim;

    atomic_result_t expected_results [$];
    atomic_result_t oldest;
    int             results_seen;

    function automatic int lookup_reservation(input logic [31:0] addr);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (resv_valid[i] && resv_addr[i] == addr)
                return i;
        end
        return -1;
    endfunction

    // Executes one atomic request against the shadow table.
    function automatic atomic_result_t execute_atomic(
        input logic [3:0]  code,
        input logic [31:0] addr,
        input logic [31:0] src,
        input logic [4:0]  rs2,
        input logic [31:0] mem
    );
        atomic_result_t res;
        int             slot;
        res = '0;
        res.status = amou_pkg::STATUS_DONE;
        case (code)
            amou_pkg::OP_LR:
            begin
                if (rs2 != 5'd0)
                    res.status = amou_pkg::STATUS_ILLEGAL;
                else
                begin
                    res.rd_write = 1'b1;
                    res.rd_value = mem;
                    if (lookup_reservation(addr) < 0)
                    begin
                        // Lowest free entry first, round-robin victim when full.
                        slot = -1;
                        for (int i = ENTRIES - 1; i >= 0; i--)
                        begin
                            if (!resv_valid[i])
                                slot = i;
                        end
                        if (slot < 0)
                        begin
                            slot = victim;
                            victim = (victim + 1) % ENTRIES;
                        end
                        resv_addr[slot] = addr;
                        resv_valid[slot] = 1'b1;
                    end
                end
            end
            amou_pkg::OP_SC:
            begin
                res.rd_write = 1'b1;
                slot = lookup_reservation(addr);
                if (slot >= 0)
                begin
                    resv_valid[slot] = 1'b0;
                    res.mem_write = 1'b1;
                    res.mem_write_value = src;
                end
                else
                    res.rd_value = 32'd1;
            end
            amou_pkg::OP_SWAP, amou_pkg::OP_ADD, amou_pkg::OP_XOR, amou_pkg::OP_AND,
            amou_pkg::OP_OR, amou_pkg::OP_MIN, amou_pkg::OP_MAX, amou_pkg::OP_MINU,
            amou_pkg::OP_MAXU:
            begin
                res.rd_write = 1'b1;
                res.rd_value = mem;
                res.mem_write = 1'b1;
                case (code)
                    amou_pkg::OP_SWAP: res.mem_write_value = src;
                    amou_pkg::OP_ADD:  res.mem_write_value = mem + src;
                    amou_pkg::OP_XOR:  res.mem_write_value = mem ^ src;
                    amou_pkg::OP_AND:  res.mem_write_value = mem & src;
                    amou_pkg::OP_OR:   res.mem_write_value = mem | src;
                    amou_pkg::OP_MIN:
                        res.mem_write_value = ($signed(mem) < $signed(src)) ? mem : src;
                    amou_pkg::OP_MAX:
                        res.mem_write_value = ($signed(mem) > $signed(src)) ? mem : src;
                    amou_pkg::OP_MINU: res.mem_write_value = (mem < src) ? mem : src;
                    default:           res.mem_write_value = (mem > src) ? mem : src;
                endcase
            end
            default:
                res.status = amou_pkg::STATUS_UNKNOWN;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
                resv_valid[i] = 1'b0;
            victim = 0;
            expected_results.delete();
            results_seen = 0;
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(execute_atomic(op, address, operand_value,
                                                          rs2_index, memory_word));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d arrived with no request outstanding",
                                 $realtime, results_seen);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (rd_write !== oldest.rd_write || rd_value !== oldest.rd_value ||
                        mem_write !== oldest.mem_write ||
                        mem_write_value !== oldest.mem_write_value ||
                        status !== oldest.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("[%0t] result %0d mismatch: expected rd %0b/%h ",
                                   $realtime, results_seen,
                                   oldest.rd_write, oldest.rd_value);
                            $write("mem %0b/%h status %0d, ",
                                   oldest.mem_write, oldest.mem_write_value,
                                   oldest.status);
                            $display("got rd %0b/%h mem %0b/%h status %0d",
                                     rd_write, rd_value, mem_write, mem_write_value,
                                     status);
                        end
                    end
                end
                results_seen++;
            end
            pending <= expected_results.size();
        end
    end

endmodule : atomic_memory_op_unit_checker

// ===== dv/atomic_memory_op_unit_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atomic_memory_op_unit_core_test
// Drives directed and random atomic requests into the atomic unit with random
// gaps on both channels, and reports the verdict from the attached checker.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit_core_test;

    localparam int         ENTRIES            = 4;
    // Codes past the last defined operation; the block must answer them with the unknown status and no writes.
    localparam logic [3:0] OP_FIRST_UNKNOWN   = 4'd11;
    localparam logic [3:0] OP_LAST_UNKNOWN    = 4'd15;
    // Number of meaningful requests in the random part.
    localparam int         RANDOM_REQUESTS    = 1460;
    // Long receiver stall that fills the block and stalls its input.
    localparam int         HOLD_AFTER_RESULTS = 200;
    localparam int         LONG_HOLD_CYCLES   = 60;
    localparam int         DRAIN_CYCLES       = 10;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_ready;
    logic [3:0]  op              = 4'd0;
    logic [31:0] address         = 32'd0;
    logic [31:0] operand_value   = 32'd0;
    logic [4:0]  rs2_index       = 5'd0;
    logic [31:0] memory_word     = 32'd0;
    logic        out_valid;
    logic        out_ready       = 1'b0;
    logic        rd_write;
    logic [31:0] rd_value;
    logic        mem_write;
    logic [31:0] mem_write_value;
    logic [1:0]  status;

    int mismatches;
    int pending;

    // Requests offered so far, and those with a defined operation; the
    // latter decide when the random part is over.
    int offered_requests  = 0;
    int counted_requests  = 0;

    always #5 clk = ~clk;

    atomic_memory_op_unit_core #(
        .RESERVATION_ENTRIES(ENTRIES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .address        (address),
        .operand_value  (operand_value),
        .rs2_index      (rs2_index),
        .memory_word    (memory_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rd_write       (rd_write),
        .rd_value       (rd_value),
        .mem_write      (mem_write),
        .mem_write_value(mem_write_value),
        .status         (status)
    );

    atomic_memory_op_unit_checker #(
        .ENTRIES(ENTRIES)
    ) checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .address        (address),
        .operand_value  (operand_value),
        .rs2_index      (rs2_index),
        .memory_word    (memory_word),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rd_write       (rd_write),
        .rd_value       (rd_value),
        .mem_write      (mem_write),
        .mem_write_value(mem_write_value),
        .status         (status),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    // Addresses are mostly drawn from a small pool so that LR and SC meet
    // each other often, and the pool is larger than the reservation table so
    // that round-robin replacement happens regularly. The rest are random.
    function automatic logic [31:0] pick_address();
        logic [31:0] pool [6];
        pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h0000_1000, 32'h0000_1004, 32'h7FFF_FFFC};
        if ($urandom_range(0, 99) < 85)
            return pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // Data words lean toward the signed and unsigned extremes, since those
    // are where min, max and add go wrong.
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offers one request after a random gap and holds it until accepted.
    // For a quarter of every 128 requests the gap is zero, giving
    // back-to-back bursts. A zero gap keeps valid high across requests, so
    // valid is never lowered and raised in the same step.
    task automatic send_request(
        input logic [3:0]  code,
        input logic [31:0] addr,
        input logic [31:0] src,
        input logic [4:0]  rs2,
        input logic [31:0] mem
    );
        int gap;
        gap = ((offered_requests % 128) < 32) ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= code;
        address       <= addr;
        operand_value <= src;
        rs2_index     <= rs2;
        memory_word   <= mem;
        do
            @(posedge clk);
        while (!in_ready);
        offered_requests++;
        if (code <= amou_pkg::OP_MAXU)
            counted_requests++;
    endtask

    // Result side: each result waits a random stall before ready is
    // raised, with stall-free stretches, and once a long hold that lets the
    // block fill up while the sender keeps offering requests.
    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        forever
        begin
            if (taken == HOLD_AFTER_RESULTS)
                stall = LONG_HOLD_CYCLES;
            else if ((taken % 96) < 24)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int          first_random;
        bit          paused;
        logic [31:0] addr;
        int          pick;
        paused = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An illegal LR and an SC with nothing reserved come
        // first, then a reserve, a repeat reserve of the same address, a
        // successful SC and a failing second SC on it.
        send_request(amou_pkg::OP_LR, 32'h0000_1000, 32'h0000_0000, 5'd31, 32'hFFFF_FFFF);
        send_request(amou_pkg::OP_SC, 32'h0000_1000, 32'h0000_1234, 5'd0, 32'h0000_0000);
        send_request(amou_pkg::OP_LR, 32'h0000_1000, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
        send_request(amou_pkg::OP_LR, 32'h0000_1000, 32'h0000_0000, 5'd0, 32'h1234_5678);
        send_request(amou_pkg::OP_SC, 32'h0000_1000, 32'hFFFF_FFFF, 5'd31, 32'h0000_0000);
        send_request(amou_pkg::OP_SC, 32'h0000_1000, 32'hFFFF_FFFF, 5'd0, 32'h0000_0000);
        // Fill the table, then overflow it twice so that the first two
        // entries are replaced in round-robin order.
        send_request(amou_pkg::OP_LR, 32'h0000_0000, 32'h0000_0000, 5'd0, 32'h0000_0001);
        send_request(amou_pkg::OP_LR, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 32'h0000_0002);
        send_request(amou_pkg::OP_LR, 32'h0000_2000, 32'h0000_0000, 5'd0, 32'h0000_0003);
        send_request(amou_pkg::OP_LR, 32'h0000_3000, 32'h0000_0000, 5'd0, 32'h0000_0004);
        send_request(amou_pkg::OP_LR, 32'h0000_4000, 32'h0000_0000, 5'd0, 32'h0000_0005);
        send_request(amou_pkg::OP_LR, 32'h0000_5000, 32'h0000_0000, 5'd0, 32'h0000_0006);
        // The evicted address fails; the replacement succeeds and frees its
        // entry, which the next LR takes without moving the victim pointer.
        send_request(amou_pkg::OP_SC, 32'h0000_0000, 32'hDEAD_BEEF, 5'd0, 32'h0000_0000);
        send_request(amou_pkg::OP_SC, 32'h0000_4000, 32'hDEAD_BEEF, 5'd0, 32'h0000_0000);
        send_request(amou_pkg::OP_LR, 32'h0000_6000, 32'h0000_0000, 5'd0, 32'h0000_0007);
        // Every AMO, with carries and the signed/unsigned boundary.
        send_request(amou_pkg::OP_SWAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 32'h0000_0000);
        send_request(amou_pkg::OP_ADD, 32'h0000_1004, 32'h0000_0001, 5'd2, 32'hFFFF_FFFF);
        send_request(amou_pkg::OP_XOR, 32'h0000_1004, 32'h5A5A_5A5A, 5'd4, 32'hA5A5_A5A5);
        send_request(amou_pkg::OP_AND, 32'h0000_1004, 32'hFFFF_0000, 5'd8, 32'hA5A5_A5A5);
        send_request(amou_pkg::OP_OR, 32'h0000_1004, 32'hFFFF_0000, 5'd16, 32'h0000_FFFF);
        send_request(amou_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 5'd31, 32'h8000_0000);
        send_request(amou_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 5'd31, 32'h8000_0000);
        send_request(amou_pkg::OP_MINU, 32'h8000_0000, 32'h7FFF_FFFF, 5'd31, 32'h8000_0000);
        send_request(amou_pkg::OP_MAXU, 32'h8000_0000, 32'h7FFF_FFFF, 5'd31, 32'h8000_0000);
        // Undefined codes at both ends of their range.
        send_request(OP_FIRST_UNKNOWN, 32'h0000_1000, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);
        send_request(OP_LAST_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);

        // Random part. A quarter of the time a well-formed LR/SC sequence on
        // one address, sometimes with an AMO in between; otherwise a single
        // request of any kind, including illegal LRs and undefined codes.
        first_random = counted_requests;
        while (counted_requests - first_random < RANDOM_REQUESTS)
        begin
            // Halfway through, stop offering until the block has drained.
            if (!paused && counted_requests - first_random >= RANDOM_REQUESTS / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                addr = pick_address();
                send_request(amou_pkg::OP_LR, addr, random_word(), 5'd0, random_word());
                if ($urandom_range(0, 1) == 1)
                    send_request(4'($urandom_range(amou_pkg::OP_SWAP, amou_pkg::OP_MAXU)),
                                 addr, random_word(), 5'($urandom_range(0, 31)),
                                 random_word());
                send_request(amou_pkg::OP_SC, addr, random_word(),
                             5'($urandom_range(0, 31)), random_word());
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 28)
                    send_request(amou_pkg::OP_LR, pick_address(), random_word(),
                                 ($urandom_range(0, 99) < 85) ? 5'd0
                                                              : 5'($urandom_range(1, 31)),
                                 random_word());
                else if (pick < 50)
                    send_request(amou_pkg::OP_SC, pick_address(), random_word(),
                                 5'($urandom_range(0, 31)), random_word());
                else if (pick < 92)
                    send_request(4'($urandom_range(amou_pkg::OP_SWAP, amou_pkg::OP_MAXU)),
                                 pick_address(), random_word(),
                                 5'($urandom_range(0, 31)), random_word());
                else
                    send_request(4'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN)),
                                 pick_address(), random_word(),
                                 5'($urandom_range(0, 31)), random_word());
            end
        end
        in_valid <= 1'b0;

        // Wait for the last result, then a few more cycles to catch any
        // stray output. The global time limit bounds this wait.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin : time_limit
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule : atomic_memory_op_unit_core_test
